// ----- src/oaht_pkg.sv -----
`timescale 1ns / 1ps
package oaht_pkg;

    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int VALUE_BITS = 32;
    localparam int KEY_W      = 64;
    localparam int HASH_LAT   = 5;

    localparam logic [63:0] HASH_ADD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_M1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_M2  = 64'h94d049bb133111eb;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_KEY_ZERO  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_PRESENT   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [1:0] {
        TAG_EMPTY  = 2'd0,
        TAG_ACTIVE = 2'd1,
        TAG_TOMB   = 2'd2
    } tag_t;

    typedef struct packed {
        tag_t                  tag;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] payload;
    } entry_t;

    // why a probe ended
    typedef enum logic [1:0] {
        END_KEYZERO = 2'd0,
        END_MATCH   = 2'd1,
        END_EMPTY   = 2'd2,
        END_EXHAUST = 2'd3
    } end_t;

    typedef struct packed {
        logic clr_wr;
        logic load_in;
        logic set_home;
        logic rd;
        logic step;
        logic finish;
        end_t why;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic key_zero;
        logic slot_empty;
        logic slot_match;
        logic last_probe;
        logic out_busy;
    } sts_t;

endpackage

// ----- src/oaht_hash.sv -----
`timescale 1ns / 1ps
module oaht_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [oaht_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [oaht_pkg::IDX_W-1:0] home
);
    import oaht_pkg::*;

    logic [HASH_LAT-1:0] vld_reg;
    logic [63:0] x1, mix1_reg, sum1, mix2_reg, sum2, fin;
    logic [63:0] ll1_reg, ll2_reg;
    logic [31:0] lh1_reg, hl1_reg, lh2_reg, hl2_reg;
    logic [IDX_W-1:0] home_reg;

    assign x1   = key + HASH_ADD;
    // 64x64 mod 2^64 from three 32x32 partial products
    assign sum1 = ll1_reg + {lh1_reg + hl1_reg, 32'd0};
    assign sum2 = ll2_reg + {lh2_reg + hl2_reg, 32'd0};
    assign fin  = sum2 ^ (sum2 >> 31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[HASH_LAT-2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        mix1_reg <= x1 ^ (x1 >> 30);
        ll1_reg  <= {32'd0, mix1_reg[31:0]} * {32'd0, HASH_M1[31:0]};
        lh1_reg  <= mix1_reg[31:0] * HASH_M1[63:32];
        hl1_reg  <= mix1_reg[63:32] * HASH_M1[31:0];
        mix2_reg <= sum1 ^ (sum1 >> 27);
        ll2_reg  <= {32'd0, mix2_reg[31:0]} * {32'd0, HASH_M2[31:0]};
        lh2_reg  <= mix2_reg[31:0] * HASH_M2[63:32];
        hl2_reg  <= mix2_reg[63:32] * HASH_M2[31:0];
        home_reg <= fin[IDX_W-1:0];
    end

    assign done = vld_reg[HASH_LAT-1];
    assign home = home_reg;

endmodule

// ----- src/oaht_ctrl.sv -----
`timescale 1ns / 1ps
module oaht_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  oaht_pkg::sts_t sts,
    output oaht_pkg::cmd_t cmd
);
    import oaht_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_READ   = 6'b001000,
        S_CHECK  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    end_t   why_reg, why_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            why_reg   <= END_KEYZERO;
        end else begin
            state_reg <= state_next;
            why_reg   <= why_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        why_next   = why_reg;
        cmd        = '0;
        cmd.why    = why_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH: begin
                if (sts.hash_done) begin
                    if (sts.key_zero) begin
                        why_next   = END_KEYZERO;
                        state_next = S_FINISH;
                    end else begin
                        cmd.set_home = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                priority if (sts.slot_empty) begin
                    why_next   = END_EMPTY;
                    state_next = S_FINISH;
                end else if (sts.slot_match) begin
                    why_next   = END_MATCH;
                    state_next = S_FINISH;
                end else begin
                    cmd.step = 1'b1;
                    if (sts.last_probe) begin
                        why_next   = END_EXHAUST;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ----- src/oaht_dp.sv -----
`timescale 1ns / 1ps
module oaht_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  oaht_pkg::cmd_t                  cmd,
    output oaht_pkg::sts_t                  sts,
    input  logic [1:0]                      s_operation,
    input  logic [oaht_pkg::KEY_W-1:0]      s_key,
    input  logic [oaht_pkg::VALUE_BITS-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic                            m_hit,
    output logic [oaht_pkg::IDX_W-1:0]      m_slot_index,
    output logic [oaht_pkg::VALUE_BITS-1:0] m_stored_value,
    output logic [oaht_pkg::CNT_W-1:0]      m_entry_count
);
    import oaht_pkg::*;

    entry_t mem [SLOTS];
    entry_t q_reg;

    logic [1:0]            op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IDX_W-1:0]      clr_idx_reg, idx_reg, probe_reg, tomb_reg;
    logic                  have_tomb_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_vld_reg;
    logic [2:0]            status_reg, status_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [VALUE_BITS-1:0] stored_reg, stored_next;

    logic             hash_done;
    logic [IDX_W-1:0] home;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             fin_wr;
    entry_t           fin_entry;
    logic [IDX_W-1:0] free_idx;

    oaht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load_in),
        .key     (s_key),
        .done    (hash_done),
        .home    (home)
    );

    assign free_idx = have_tomb_reg ? tomb_reg : idx_reg;

    // result of a finished transaction and the table write it implies
    always_comb begin
        status_next = ST_OK;
        hit_next    = 1'b0;
        slot_next   = '0;
        stored_next = '0;
        count_next  = count_reg;
        fin_wr      = 1'b0;
        fin_entry   = '{tag: TAG_ACTIVE, key: key_reg, payload: val_reg};
        unique case (cmd.why)
            END_KEYZERO: status_next = ST_KEY_ZERO;
            END_MATCH: begin
                hit_next  = 1'b1;
                slot_next = idx_reg;
                if (op_reg == OP_REMOVE) begin
                    fin_wr     = 1'b1;
                    fin_entry  = '{tag: TAG_TOMB, key: '0, payload: '0};
                    if (count_reg != '0) count_next = count_reg - 1'b1;
                end else begin
                    stored_next = q_reg.payload;
                    if (op_reg == OP_INSERT) status_next = ST_PRESENT;
                end
            end
            END_EMPTY: begin
                if (op_reg == OP_INSERT) begin
                    fin_wr     = 1'b1;
                    slot_next  = free_idx;
                    count_next = count_reg + 1'b1;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            END_EXHAUST: begin
                if (op_reg != OP_INSERT) begin
                    status_next = ST_NOT_FOUND;
                end else if (have_tomb_reg) begin
                    fin_wr     = 1'b1;
                    slot_next  = tomb_reg;
                    count_next = count_reg + 1'b1;
                end else begin
                    status_next = ST_FULL;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    assign we    = cmd.clr_wr || (cmd.finish && fin_wr);
    assign waddr = cmd.clr_wr ? clr_idx_reg : (cmd.why == END_MATCH ? idx_reg : free_idx);
    assign wdata = cmd.clr_wr ? '{tag: TAG_EMPTY, key: '0, payload: '0} : fin_entry;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd) q_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.finish) begin
                count_reg   <= count_next;
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_operation;
            key_reg <= s_key;
            val_reg <= s_value;
        end
        if (cmd.set_home) begin
            idx_reg       <= home;
            probe_reg     <= '0;
            have_tomb_reg <= 1'b0;
        end else if (cmd.step) begin
            idx_reg   <= idx_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
            if (q_reg.tag == TAG_TOMB && !have_tomb_reg) begin
                have_tomb_reg <= 1'b1;
                tomb_reg      <= idx_reg;
            end
        end
        if (cmd.finish) begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            slot_reg   <= slot_next;
            stored_reg <= stored_next;
        end
    end

    assign sts.clr_last   = (clr_idx_reg == IDX_W'(SLOTS - 1));
    assign sts.hash_done  = hash_done;
    assign sts.key_zero   = (key_reg == '0);
    assign sts.slot_empty = (q_reg.tag == TAG_EMPTY);
    assign sts.slot_match = (q_reg.tag == TAG_ACTIVE) && (q_reg.key == key_reg);
    assign sts.last_probe = (probe_reg == IDX_W'(SLOTS - 1));
    assign sts.out_busy   = out_vld_reg && !m_ready;

    assign m_valid        = out_vld_reg;
    assign m_status       = status_reg;
    assign m_hit          = hit_reg;
    assign m_slot_index   = slot_reg;
    assign m_stored_value = stored_reg;
    assign m_entry_count  = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("active count above table size");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_vld_reg || m_ready))
        else $error("result overwritten before transfer");

    a_rd_not_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> !we)
        else $error("table read and write in one cycle");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && fin_wr && op_reg == OP_INSERT) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not bump count");
`endif

endmodule

// ----- src/open_addressed_hash_table.sv -----
`timescale 1ns / 1ps
// channel  | ports                                            | direction
// s_       | s_operation, s_key, s_value                      | in
// m_       | m_status, m_hit, m_slot_index, m_stored_value,   | out
//          | m_entry_count                                    |
// One transaction at a time: accept, hash, then a read and a check per slot
// probed, then the result into the output register.
// The slot memory is read once per probe, in S_READ, and the slot is checked in S_CHECK.
// After reset the table is swept empty, with s_ready low.
// A result waiting on m_ready holds the output register; s_ready stays up
// so the next transaction is taken and runs up to its finish.
module open_addressed_hash_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_operation,
    input  logic [oaht_pkg::KEY_W-1:0]      s_key,
    input  logic [oaht_pkg::VALUE_BITS-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic                            m_hit,
    output logic [oaht_pkg::IDX_W-1:0]      m_slot_index,
    output logic [oaht_pkg::VALUE_BITS-1:0] m_stored_value,
    output logic [oaht_pkg::CNT_W-1:0]      m_entry_count
);
    import oaht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oaht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    oaht_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_operation    (s_operation),
        .s_key          (s_key),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_hit          (m_hit),
        .m_slot_index   (m_slot_index),
        .m_stored_value (m_stored_value),
        .m_entry_count  (m_entry_count)
    );

endmodule

// ----- test/open_addressed_hash_table_tb.sv -----
`timescale 1ns / 1ps
module open_addressed_hash_table_tb;
    import oaht_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    // unused operation code, handled as a lookup
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]            op;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } request_t;

    typedef struct {
        logic [2:0]            status;
        logic                  hit;
        logic [IDX_W-1:0]      slot;
        logic [VALUE_BITS-1:0] stored;
        logic [CNT_W-1:0]      count;
    } reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation = '0;
    logic [KEY_W-1:0]      s_key = '0;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_status;
    logic                  m_hit;
    logic [IDX_W-1:0]      m_slot_index;
    logic [VALUE_BITS-1:0] m_stored_value;
    logic [CNT_W-1:0]      m_entry_count;

    open_addressed_hash_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_key(s_key), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_hit(m_hit), .m_slot_index(m_slot_index),
        .m_stored_value(m_stored_value), .m_entry_count(m_entry_count)
    );

    always #5 aclk = ~aclk;

    // shadow table
    tag_t                  shadow_tag[SLOTS];
    logic [KEY_W-1:0]      shadow_key[SLOTS];
    logic [VALUE_BITS-1:0] shadow_payload[SLOTS];
    logic [CNT_W-1:0]      shadow_active;

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    logic [KEY_W-1:0] key_pool[$];
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  stimulus_done = 1'b0;

    // accept flag from the last rising edge, so the driver knows to move on
    bit s_ready_seen = 1'b0;

    function automatic logic [IDX_W-1:0] hash_home(logic [63:0] k);
        logic [63:0] x;
        x = k + HASH_ADD;
        x = (x ^ (x >> 30)) * HASH_M1;
        x = (x ^ (x >> 27)) * HASH_M2;
        x = x ^ (x >> 31);
        return x[IDX_W-1:0];
    endfunction

    function automatic bit find_active(logic [63:0] k, output logic [IDX_W-1:0] where);
        logic [IDX_W-1:0] i;
        i = hash_home(k);
        where = '0;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_tag[i] == TAG_EMPTY) return 1'b0;
            if (shadow_tag[i] == TAG_ACTIVE && shadow_key[i] == k) begin
                where = i;
                return 1'b1;
            end
            i = i + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit find_free(logic [63:0] k, output logic [IDX_W-1:0] where);
        logic [IDX_W-1:0] i;
        bit have_tomb;
        logic [IDX_W-1:0] tomb;
        i = hash_home(k);
        have_tomb = 1'b0;
        tomb = '0;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_tag[i] == TAG_TOMB && !have_tomb) begin
                have_tomb = 1'b1;
                tomb = i;
            end
            if (shadow_tag[i] == TAG_EMPTY) begin
                where = have_tomb ? tomb : i;
                return 1'b1;
            end
            i = i + 1'b1;
        end
        where = tomb;
        return have_tomb;
    endfunction

    function automatic reply_t apply_request(request_t r);
        reply_t e;
        logic [IDX_W-1:0] w;
        e = '{ST_OK, 1'b0, '0, '0, '0};
        if (r.key == '0) begin
            e.status = ST_KEY_ZERO;
        end else if (r.op == OP_INSERT) begin
            if (find_active(r.key, w)) begin
                e.status = ST_PRESENT;
                e.hit = 1'b1;
                e.slot = w;
                e.stored = shadow_payload[w];
            end else if (find_free(r.key, w)) begin
                shadow_tag[w] = TAG_ACTIVE;
                shadow_key[w] = r.key;
                shadow_payload[w] = r.value;
                shadow_active = shadow_active + 1'b1;
                e.slot = w;
            end else begin
                e.status = ST_FULL;
            end
        end else if (r.op == OP_REMOVE) begin
            if (find_active(r.key, w)) begin
                shadow_tag[w] = TAG_TOMB;
                if (shadow_active != 0) shadow_active = shadow_active - 1'b1;
                e.hit = 1'b1;
                e.slot = w;
            end else begin
                e.status = ST_NOT_FOUND;
            end
        end else begin
            // lookup, and the spare code behaves as one
            if (find_active(r.key, w)) begin
                e.hit = 1'b1;
                e.slot = w;
                e.stored = shadow_payload[w];
            end else begin
                e.status = ST_NOT_FOUND;
            end
        end
        e.count = shadow_active;
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (pending_requests.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= r.op;
                    s_key <= r.key;
                    s_value <= r.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= stimulus_done || ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        s_ready_seen <= 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                request_t r;
                r = '{s_operation, s_key, s_value};
                s_ready_seen <= 1'b1;
                expected_replies.push_back(apply_request(r));
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_status), 64'd0);
                end else begin
                    reply_t e;
                    e = expected_replies.pop_front();
                    if (m_status !== e.status) report_mismatch("status", 64'(m_status), 64'(e.status));
                    if (m_hit !== e.hit) report_mismatch("hit", 64'(m_hit), 64'(e.hit));
                    if (m_slot_index !== e.slot)
                        report_mismatch("slot_index", 64'(m_slot_index), 64'(e.slot));
                    if (m_stored_value !== e.stored)
                        report_mismatch("stored_value", 64'(m_stored_value), 64'(e.stored));
                    if (m_entry_count !== e.count)
                        report_mismatch("entry_count", 64'(m_entry_count), 64'(e.count));
                end
            end
            // the post-reset sweep counts as quiet time, so the limit covers it
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_request(logic [1:0] op, logic [63:0] k, logic [31:0] v);
        request_t r;
        r = '{op, k, v};
        pending_requests.push_back(r);
    endtask

    function automatic logic [63:0] pool_key();
        if (key_pool.size() == 0 || $urandom_range(9, 0) == 0) return rand_key();
        return key_pool[$urandom_range(key_pool.size() - 1, 0)];
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            int pick;
            logic [63:0] k;
            pick = $urandom_range(99, 0);
            if (pick < 3) begin
                queue_request(2'($urandom_range(3, 0)), 64'd0, $urandom());
            end else if (pick < 45) begin
                k = ($urandom_range(3, 0) == 0) ? rand_key() : pool_key();
                if (key_pool.size() < 400) key_pool.push_back(k);
                queue_request(OP_INSERT, k, $urandom());
            end else if (pick < 70) begin
                queue_request(OP_REMOVE, pool_key(), $urandom());
            end else if (pick < 75) begin
                queue_request(OP_SPARE, pool_key(), $urandom());
            end else begin
                queue_request(OP_LOOKUP, pool_key(), $urandom());
            end
        end
    endtask

    task automatic drain();
        wait (pending_requests.size() == 0 && !s_valid);
        wait (expected_replies.size() == 0);
    endtask

    initial begin
        foreach (shadow_tag[i]) shadow_tag[i] = TAG_EMPTY;
        shadow_active = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: key zero for each code, extremes, duplicates, tombstone reuse
        for (int op = 0; op < 4; op++) queue_request(2'(op), 64'd0, 32'hFFFF_FFFF);
        queue_request(OP_LOOKUP, 64'd1, 32'd0);
        queue_request(OP_INSERT, 64'd1, 32'h0000_0000);
        queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        queue_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        queue_request(OP_SPARE, 64'd1, 32'd0);
        queue_request(OP_INSERT, 64'hAAAA_AAAA_5555_5555, 32'hAAAA_5555);
        queue_request(OP_INSERT, 64'h5555_5555_AAAA_AAAA, 32'h5555_AAAA);
        queue_request(OP_REMOVE, 64'd1, 32'd0);
        queue_request(OP_REMOVE, 64'd1, 32'd0);
        queue_request(OP_LOOKUP, 64'd1, 32'd0);
        queue_request(OP_INSERT, 64'd1, 32'hDEAD_BEEF);
        queue_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        queue_request(OP_REMOVE, 64'hAAAA_AAAA_5555_5555, 32'd0);
        queue_request(OP_REMOVE, 64'h5555_5555_AAAA_AAAA, 32'd0);
        queue_request(OP_REMOVE, 64'd1, 32'd0);
        queue_request(OP_REMOVE, 64'd2, 32'd0);
        queue_request(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'd0);
        drain();

        random_phase(350);
        drain();
        idle_pct = 86;
        random_phase(300);
        drain();
        idle_pct = 0;
        stall_pct = 86;
        random_phase(300);
        drain();
        idle_pct = 11;
        stall_pct = 11;
        random_phase(330);
        drain();

        stimulus_done = 1'b1;
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
